// ----- hw/rtl/teq_pkg.sv -----
// Shared types and constants for the typed event queue.
// Holds the depth, slot and count widths, the item structs and the sequencer states.
// No dependencies.
`default_nettype none

package teq_pkg;

  localparam int unsigned QUEUE_DEPTH = 1024;
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IDX_W-1:0] slot_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam slot_t SLOT_LAST = slot_t'(QUEUE_DEPTH - 1);
  localparam cnt_t CNT_FULL = cnt_t'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_RECV  = 2'd1,
    OP_PEEK  = 2'd2,
    OP_COUNT = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] event_type;
    logic [31:0] event_value;
    logic [31:0] time_stamp;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [15:0] found_type;
    logic [31:0] found_value;
    logic [31:0] found_time;
    logic [10:0] entry_total;
    logic        oldest_dropped;
  } out_t;

  typedef struct packed {
    logic [15:0] ev_type;
    logic [31:0] ev_value;
    logic [31:0] ev_time;
    slot_t       link;
  } entry_t;

  typedef struct packed {
    logic        data_we;
    slot_t       data_addr;
    logic [15:0] ev_type;
    logic [31:0] ev_value;
    logic [31:0] ev_time;
    logic        link_we;
    slot_t       link_addr;
    slot_t       link_data;
  } wr_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DROP_RD,
    ST_DROP,
    ST_ALLOC_RD,
    ST_ALLOC,
    ST_WALK_RD,
    ST_WALK,
    ST_UNLINK,
    ST_RELEASE,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/teq_store.sv -----
// Entry memories of the event queue: type, value, time stamp and link per slot.
// One shared read address with registered data; separate data and link write ports.
// Depends on teq_pkg.
`default_nettype none

module teq_store
  import teq_pkg::*;
(
  input  wire    clk_i,
  input  slot_t  rd_addr_i,
  input  wr_t    wr_i,
  output entry_t rd_o
);

  logic [15:0] type_mem  [QUEUE_DEPTH];
  logic [31:0] value_mem [QUEUE_DEPTH];
  logic [31:0] stamp_mem [QUEUE_DEPTH];
  slot_t       link_mem  [QUEUE_DEPTH];
  entry_t      rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.data_we) begin
      type_mem[wr_i.data_addr]  <= wr_i.ev_type;
      value_mem[wr_i.data_addr] <= wr_i.ev_value;
      stamp_mem[wr_i.data_addr] <= wr_i.ev_time;
    end
    if (wr_i.link_we) begin
      link_mem[wr_i.link_addr] <= wr_i.link_data;
    end
    rd_q.ev_type  <= type_mem[rd_addr_i];
    rd_q.ev_value <= value_mem[rd_addr_i];
    rd_q.ev_time  <= stamp_mem[rd_addr_i];
    rd_q.link     <= link_mem[rd_addr_i];
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

// ----- hw/rtl/typed_event_queue_unit.sv -----
// Typed event queue: a sequencer walks linked entries through one memory read port.
// Send may drop the oldest entry when full; receive and peek walk the list from the head.
// One item at a time; the input is stalled until the result has been handed to the output register.
// After reset the link memory is initialized as a free list before the first item is taken.
// Depends on teq_pkg and teq_store.
`default_nettype none

module typed_event_queue_unit
  import teq_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output out_t out_item_o
);

  state_e state_q, state_d;
  slot_t  head_q, head_d, tail_q, tail_d, free_q, free_d;
  slot_t  el_q, el_d, prev_q, prev_d, clr_q, clr_d;
  cnt_t   count_q, count_d, seen_q, seen_d;
  logic   out_valid_q, out_valid_d;
  in_t    cmd_q, cmd_d;
  logic [31:0] ord_q, ord_d;
  out_t   res_q, res_d, out_q, out_d;
  slot_t  rd_addr;
  wr_t    wr;
  entry_t rd;
  logic   full, last, match, out_free;

  teq_store u_store (
    .clk_i    (clk_i),
    .rd_addr_i(rd_addr),
    .wr_i     (wr),
    .rd_o     (rd)
  );

  assign full       = (count_q == CNT_FULL);
  assign last       = (seen_q >= count_q);
  assign match      = (cmd_q.event_type == 16'd0) || (rd.ev_type == cmd_q.event_type);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:    if (clr_q == SLOT_LAST) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_item_i.opcode)
            OP_SEND:  state_d = full ? ST_DROP_RD : ST_ALLOC_RD;
            OP_COUNT: state_d = ST_EMIT;
            default:  state_d = (count_q == '0) ? ST_EMIT : ST_WALK_RD;
          endcase
        end
      end
      ST_DROP_RD:  state_d = ST_DROP;
      ST_DROP:     state_d = ST_ALLOC_RD;
      ST_ALLOC_RD: state_d = ST_ALLOC;
      ST_ALLOC:    state_d = ST_EMIT;
      ST_WALK_RD:  state_d = ST_WALK;
      ST_WALK: begin
        if (cmd_q.opcode == OP_RECV) begin
          priority if (match) state_d = ST_UNLINK;
          else if (last)      state_d = ST_EMIT;
          else                state_d = ST_WALK_RD;
        end else begin
          priority if (match && ord_q <= 32'd1) state_d = ST_EMIT;
          else if (last)                        state_d = ST_EMIT;
          else                                  state_d = ST_WALK_RD;
        end
      end
      ST_UNLINK:   state_d = ST_RELEASE;
      ST_RELEASE:  state_d = ST_EMIT;
      ST_EMIT:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    head_d = head_q; tail_d = tail_q; free_d = free_q;
    el_d = el_q; prev_d = prev_q; clr_d = clr_q;
    count_d = count_q; seen_d = seen_q;
    cmd_d = cmd_q; ord_d = ord_q; res_d = res_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_addr = el_q;
    wr = '0;
    unique case (state_q)
      ST_CLEAR: begin
        wr.link_we   = 1'b1;
        wr.link_addr = clr_q;
        wr.link_data = (clr_q == SLOT_LAST) ? '0 : clr_q + slot_t'(1);
        clr_d = clr_q + slot_t'(1);
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = in_item_i;
          ord_d  = in_item_i.event_value;
          el_d   = head_q;
          prev_d = head_q;
          seen_d = cnt_t'(1);
          res_d  = '0;
          res_d.entry_total = 11'(count_q);
          if ((in_item_i.opcode == OP_RECV || in_item_i.opcode == OP_PEEK)
              && count_q == '0) begin
            res_d.status = 1'b1;
          end
        end
      end
      ST_DROP_RD: rd_addr = head_q;
      ST_DROP: begin
        head_d       = rd.link;
        wr.link_we   = 1'b1;
        wr.link_addr = head_q;
        wr.link_data = free_q;
        free_d       = head_q;
        count_d      = count_q - cnt_t'(1);
        res_d.oldest_dropped = 1'b1;
      end
      ST_ALLOC_RD: rd_addr = free_q;
      ST_ALLOC: begin
        free_d       = rd.link;
        wr.data_we   = 1'b1;
        wr.data_addr = free_q;
        wr.ev_type   = cmd_q.event_type;
        wr.ev_value  = cmd_q.event_value;
        wr.ev_time   = cmd_q.time_stamp;
        if (count_q == '0) begin
          head_d = free_q;
        end else begin
          wr.link_we   = 1'b1;
          wr.link_addr = tail_q;
          wr.link_data = free_q;
        end
        tail_d  = free_q;
        count_d = count_q + cnt_t'(1);
        res_d.entry_total = 11'(count_q + cnt_t'(1));
      end
      ST_WALK: begin
        if (match && (cmd_q.opcode == OP_RECV || ord_q <= 32'd1)) begin
          res_d.found_type  = rd.ev_type;
          res_d.found_value = rd.ev_value;
          res_d.found_time  = rd.ev_time;
        end else begin
          if (match) ord_d = ord_q - 32'd1;
          if (last) begin
            res_d.status = 1'b1;
          end else begin
            prev_d = el_q;
            el_d   = rd.link;
            seen_d = seen_q + cnt_t'(1);
          end
        end
      end
      ST_UNLINK: begin
        if (el_q == head_q) begin
          head_d = rd.link;
        end else begin
          wr.link_we   = 1'b1;
          wr.link_addr = prev_q;
          wr.link_data = rd.link;
        end
        if (el_q == tail_q) tail_d = prev_q;
      end
      ST_RELEASE: begin
        wr.link_we   = 1'b1;
        wr.link_addr = el_q;
        wr.link_data = free_q;
        free_d       = el_q;
        count_d      = count_q - cnt_t'(1);
        res_d.entry_total = 11'(count_q - cnt_t'(1));
      end
      ST_EMIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      head_q      <= '0;
      tail_q      <= '0;
      free_q      <= '0;
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_q      <= free_d;
      count_q     <= count_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    el_q   <= el_d;
    prev_q <= prev_d;
    seen_q <= seen_d;
    cmd_q  <= cmd_d;
    ord_q  <= ord_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire
